// ----- hw/rtl/dtbp_pkg.sv -----
`default_nettype none

package dtbp_pkg;

  // field and datapath widths
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned TOK_W    = 32;
  localparam int unsigned CNT_W    = 64;
  localparam int unsigned Q_W      = 32;
  localparam int unsigned PROD_W   = 96;
  localparam int unsigned DIV_W    = 62;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned LEN_SHIFT = 3;

  // divide by 1e9 = 2^9 * 5^9: shift, reciprocal multiply, fix-up
  localparam int unsigned DIV_SHIFT  = 9;
  localparam int unsigned PDIV_W     = DIV_W - DIV_SHIFT;
  localparam int unsigned RECIP_W    = 33;
  localparam int unsigned NSD_W      = 21;
  localparam int unsigned RLO_W      = 32 + RECIP_W;
  localparam int unsigned RHI_W      = PDIV_W - 32 + RECIP_W;
  localparam int unsigned RPROD_W    = PDIV_W + RECIP_W;
  // reciprocal multiply (two stages), remainder product, fix-up
  localparam int unsigned DIV_STAGES = 4;

  localparam logic [DIV_W-1:0]  NS_PER_SEC = DIV_W'(64'd1_000_000_000);
  // rate * elapsed at or above this gives a refill of 2^32 or more
  localparam logic [PROD_W-1:0] SAT_LIMIT  = PROD_W'(NS_PER_SEC) << Q_W;
  // odd part of 1e9 (5^9)
  localparam logic [NSD_W-1:0]  NS_ODD     = NSD_W'(NS_PER_SEC >> DIV_SHIFT);
  // floor(2^53 / 5^9); the quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] NS_RECIP  = RECIP_W'((64'd1 << PDIV_W) / 64'(NS_ODD));

  typedef enum logic [1:0] {
    REG_RX_RATE  = 2'd0,
    REG_RX_BURST = 2'd1,
    REG_TX_RATE  = 2'd2,
    REG_TX_BURST = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TOK_W-1:0] rx_rate;
    logic [TOK_W-1:0] rx_burst;
    logic [TOK_W-1:0] tx_rate;
    logic [TOK_W-1:0] tx_burst;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             dir;
    logic [LEN_W-1:0] len;
    logic             rate_zero;
    logic             sat;
    logic [Q_W-1:0]   q;
  } refill_t;

  typedef struct packed {
    logic             accept;
    logic [TOK_W-1:0] tokens_left;
    logic [CNT_W-1:0] byte_total;
    logic [CNT_W-1:0] packet_total;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dtbp_in_if.sv -----
`default_nettype none

interface dtbp_in_if;
  logic        valid;
  logic        ready;
  logic        direction_out;
  logic [15:0] packet_length;
  logic [63:0] now_ns;

  modport source (output valid, direction_out, packet_length, now_ns, input ready);
  modport sink   (input valid, direction_out, packet_length, now_ns, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dtbp_out_if.sv -----
`default_nettype none

interface dtbp_out_if;
  logic        valid;
  logic        ready;
  logic        accept;
  logic [31:0] tokens_left;
  logic [63:0] byte_total;
  logic [63:0] packet_total;

  modport source (output valid, accept, tokens_left, byte_total, packet_total, input ready);
  modport sink   (input valid, accept, tokens_left, byte_total, packet_total, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dtbp_cfg.sv -----
`default_nettype none

module dtbp_cfg import dtbp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_RX_RATE:  cfg.rx_rate  <= pwdata;
        REG_RX_BURST: cfg.rx_burst <= pwdata;
        REG_TX_RATE:  cfg.tx_rate  <= pwdata;
        REG_TX_BURST: cfg.tx_burst <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RX_RATE:  prdata = cfg.rx_rate;
      REG_RX_BURST: prdata = cfg.rx_burst;
      REG_TX_RATE:  prdata = cfg.tx_rate;
      REG_TX_BURST: prdata = cfg.tx_burst;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dtbp_refill.sv -----
`default_nettype none

module dtbp_refill import dtbp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              take,
  input  wire logic              dir,
  input  wire logic [LEN_W-1:0]  len,
  input  wire logic [TIME_W-1:0] now,
  input  cfg_t                   cfg,
  output refill_t                r
);

  // last time stamp per direction, updated for every packet
  logic [TIME_W-1:0] last_time [2];

  // elapsed time stage
  logic              a_valid;
  logic              a_dir;
  logic [LEN_W-1:0]  a_len;
  logic [TIME_W-1:0] a_elapsed;

  // partial product stage
  logic              b_valid;
  logic              b_dir;
  logic [LEN_W-1:0]  b_len;
  logic              b_rate_zero;
  logic [63:0]       b_lo;
  logic [63:0]       b_hi;
  logic [TOK_W-1:0]  rate;
  logic [PROD_W-1:0] prod;

  // sideband through the divide stages; index 0 is the product sum stage
  logic              s_valid     [DIV_STAGES+1];
  logic              s_dir       [DIV_STAGES+1];
  logic [LEN_W-1:0]  s_len       [DIV_STAGES+1];
  logic              s_rate_zero [DIV_STAGES+1];
  logic              s_sat       [DIV_STAGES+1];

  // product with the 2^9 factor shifted out, then divided by 5^9
  logic [PDIV_W-1:0]  c_pdiv;
  logic [PDIV_W-1:0]  d_pdiv;
  logic [RLO_W-1:0]   d_lo;
  logic [RHI_W-1:0]   d_hi;
  logic [RPROD_W-1:0] qprod;
  logic [PDIV_W-1:0]  e_pdiv;
  logic [Q_W-1:0]     e_q;
  logic [PDIV_W-1:0]  f_pdiv;
  logic [Q_W-1:0]     f_q;
  logic [PDIV_W-1:0]  f_qd;
  logic [PDIV_W-1:0]  rem;
  logic [Q_W-1:0]     g_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time[0] <= '0;
      last_time[1] <= '0;
      a_valid      <= 1'b0;
    end else if (en) begin
      a_valid <= take;
      if (take) begin
        last_time[dir] <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dir     <= dir;
      a_len     <= len;
      a_elapsed <= now - last_time[dir];
    end
  end

  assign rate = a_dir ? cfg.tx_rate : cfg.rx_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_dir       <= a_dir;
      b_len       <= a_len;
      b_rate_zero <= (rate == '0);
      b_lo        <= 64'(rate) * 64'(a_elapsed[31:0]);
      b_hi        <= 64'(rate) * 64'(a_elapsed[63:32]);
    end
  end

  assign prod = PROD_W'(b_lo) + (PROD_W'(b_hi) << 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else if (en) begin
      s_valid[0] <= b_valid;
    end
  end

  // below the saturation limit the product fits DIV_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      s_dir[0]       <= b_dir;
      s_len[0]       <= b_len;
      s_rate_zero[0] <= b_rate_zero;
      s_sat[0]       <= (prod >= SAT_LIMIT);
      c_pdiv         <= prod[DIV_W-1:DIV_SHIFT];
    end
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[i+1] <= 1'b0;
      end else if (en) begin
        s_valid[i+1] <= s_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_dir[i+1]       <= s_dir[i];
        s_len[i+1]       <= s_len[i];
        s_rate_zero[i+1] <= s_rate_zero[i];
        s_sat[i+1]       <= s_sat[i];
      end
    end
  end

  // reciprocal partial products
  always_ff @(posedge clk) begin
    if (en) begin
      d_pdiv <= c_pdiv;
      d_lo   <= RLO_W'(c_pdiv[31:0]) * RLO_W'(NS_RECIP);
      d_hi   <= RHI_W'(c_pdiv[PDIV_W-1:32]) * RHI_W'(NS_RECIP);
    end
  end

  // quotient estimate, at most one below the true quotient
  assign qprod = RPROD_W'(d_lo) + (RPROD_W'(d_hi) << 32);

  always_ff @(posedge clk) begin
    if (en) begin
      e_pdiv <= d_pdiv;
      e_q    <= qprod[PDIV_W +: Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_pdiv <= e_pdiv;
      f_q    <= e_q;
      f_qd   <= PDIV_W'(e_q) * PDIV_W'(NS_ODD);
    end
  end

  // remainder below 2 * 5^9; bump the estimate when it reaches 5^9
  assign rem = f_pdiv - f_qd;

  always_ff @(posedge clk) begin
    if (en) begin
      g_q <= f_q + Q_W'(rem >= PDIV_W'(NS_ODD));
    end
  end

  assign r.valid     = s_valid[DIV_STAGES];
  assign r.dir       = s_dir[DIV_STAGES];
  assign r.len       = s_len[DIV_STAGES];
  assign r.rate_zero = s_rate_zero[DIV_STAGES];
  assign r.sat       = s_sat[DIV_STAGES];
  assign r.q         = g_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dtbp_bucket.sv -----
`default_nettype none

module dtbp_bucket import dtbp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  refill_t   r,
  input  cfg_t      cfg,
  output logic      push,
  output res_t      res
);

  logic [TOK_W-1:0] tokens  [2];
  logic [CNT_W-1:0] bytes   [2];
  logic [CNT_W-1:0] packets [2];

  logic [TOK_W-1:0] tok;
  logic [TOK_W-1:0] burst;
  logic [TOK_W:0]   sum;
  logic             over;
  logic [TOK_W-1:0] tok_full;
  logic [TOK_W-1:0] bits;
  logic             pass;
  logic [TOK_W-1:0] tokens_next;
  logic [CNT_W-1:0] bytes_next;
  logic [CNT_W-1:0] packets_next;

  assign push  = en && r.valid;
  assign tok   = tokens[r.dir];
  assign burst = r.dir ? cfg.tx_burst : cfg.rx_burst;

  // refill and cap at the burst; a saturated refill always overflows
  assign sum      = {1'b0, tok} + {1'b0, r.q};
  assign over     = r.sat || (sum > {1'b0, burst});
  assign tok_full = over ? burst : sum[TOK_W-1:0];

  assign bits = TOK_W'(r.len) << LEN_SHIFT;
  assign pass = (bits <= tok_full) || r.rate_zero;

  // rate zero passes everything and spends no tokens
  assign tokens_next  = (pass && !r.rate_zero) ? (tok_full - bits) : tok_full;
  assign bytes_next   = bytes[r.dir] + (pass ? CNT_W'(r.len) : '0);
  assign packets_next = packets[r.dir] + (pass ? CNT_W'(1) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      tokens[0]  <= '0;
      tokens[1]  <= '0;
      bytes[0]   <= '0;
      bytes[1]   <= '0;
      packets[0] <= '0;
      packets[1] <= '0;
    end else if (push) begin
      tokens[r.dir]  <= tokens_next;
      bytes[r.dir]   <= bytes_next;
      packets[r.dir] <= packets_next;
    end
  end

  assign res.accept       = pass;
  assign res.tokens_left  = tokens_next;
  assign res.byte_total   = bytes_next;
  assign res.packet_total = packets_next;

endmodule

`default_nettype wire

// ----- hw/rtl/dtbp_out_fifo.sv -----
`default_nettype none

module dtbp_out_fifo import dtbp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  res_t        wdata,
  output logic        full,
  dtbp_out_if.source  res
);

  res_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop  = res.valid && res.ready;
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  assign res.valid        = (count != 2'd0);
  assign res.accept       = slot[rd_ptr].accept;
  assign res.tokens_left  = slot[rd_ptr].tokens_left;
  assign res.byte_total   = slot[rd_ptr].byte_total;
  assign res.packet_total = slot[rd_ptr].packet_total;

endmodule

`default_nettype wire

// ----- hw/rtl/dual_token_bucket_policer_top.sv -----
`default_nettype none

// two-direction token bucket policer for one session. each packet beat on pkt
// carries direction, ip total length and a nanosecond time stamp; the block
// refills that direction's bucket by floor(rate * elapsed / 1e9), caps it at
// the burst, passes the packet if length * 8 fits or the rate is zero, and
// returns one result beat with the verdict, the tokens left and the accepted
// byte and packet totals of that direction. one packet is taken every cycle
// while the output buffer has room. a packet goes through the refill pipeline:
// elapsed-time stage, split 32x64 multiply, product sum and saturation check,
// then four stages of divide by 1e9: the 2^9 factor is a shift, a split 32x33
// reciprocal multiply of 5^9 gives a quotient at most one low, and a 32x21
// multiply with a remainder compare fixes it up. the bucket and counter update
// is done at the pipeline end as the beat enters the buffer, so packets of the
// same direction may follow each other back to back. a two-beat output buffer
// decouples res from pkt; while it is full the whole pipeline holds. registers
// sit on the apb port at byte offsets 0 inbound rate (bits/s), 4 inbound burst
// (bits), 8 outbound rate, 12 outbound burst; write them only while no packet
// is in flight

module dual_token_bucket_policer_top import dtbp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  dtbp_in_if.sink                pkt,
  dtbp_out_if.source             res,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t    cfg;
  refill_t refill;
  res_t    result;
  logic    push;
  logic    full;
  logic    en;
  logic    take;

  // whole pipeline advances while the output buffer has room
  assign en        = !full;
  assign pkt.ready = en;
  assign take      = pkt.valid && en;

  dtbp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // elapsed time, rate product and divide by 1e9
  dtbp_refill u_refill (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .take (take),
    .dir  (pkt.direction_out),
    .len  (pkt.packet_length),
    .now  (pkt.now_ns),
    .cfg  (cfg),
    .r    (refill)
  );

  // bucket state and counters, committed as the beat enters the buffer
  dtbp_bucket u_bucket (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .r    (refill),
    .cfg  (cfg),
    .push (push),
    .res  (result)
  );

  dtbp_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (result),
    .full  (full),
    .res   (res)
  );

endmodule

`default_nettype wire

// ----- dv/dual_token_bucket_policer_top_test.sv -----
`default_nettype none

module dual_token_bucket_policer_top_test import dtbp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // direction codes on the packet channel
  localparam logic DIR_IN  = 1'b0;
  localparam logic DIR_OUT = 1'b1;

  // refill math: one second in ns, and the refill ceiling (above any burst)
  localparam logic [95:0] ONE_SEC_NS  = 96'd1_000_000_000;
  localparam logic [95:0] REFILL_CEIL = 96'h1_0000_0000;

  // covers the pipeline depth, with margin, once the last result is in
  localparam int unsigned PIPE_SLACK = 12;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  logic clk;
  logic rst;

  dtbp_in_if  pkt_if ();
  dtbp_out_if res_if ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dual_token_bucket_policer_top dut (
    .clk     (clk),
    .rst     (rst),
    .pkt     (pkt_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // per-direction policer state as the block should hold it
  typedef struct {
    logic [31:0] rate;
    logic [31:0] burst;
    logic [31:0] tokens;
    logic [63:0] last_stamp;
    logic [63:0] bytes;
    logic [63:0] packets;
  } bucket_t;

  bucket_t bkt [2];

  // verdicts still owed by the block, oldest first
  res_t verdict_q [$];

  // shared time base for the random traffic
  logic [63:0] clock_ns;

  // idling controls for the packet sender and the result receiver
  bit pkt_gaps;
  bit res_stalls;

  int unsigned mismatches;
  int unsigned packets_sent;
  int unsigned packets_passed;
  int unsigned packets_dropped;
  int unsigned results_checked;
  int unsigned reg_writes;
  int unsigned policies;

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("timeout: %0d verdicts still owed", verdict_q.size());
    $display("[dual_token_bucket_policer_top] ERROR");
    $finish;
  end

  // one line per mismatch, and a running count
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // refill, police and count one packet; returns the verdict beat the block owes
  function automatic res_t police_packet(input logic is_out, input logic [15:0] len,
                                         input logic [63:0] stamp);
    logic [63:0] elapsed;
    logic [95:0] refill;
    logic [32:0] level;
    logic [31:0] bits;
    logic        pass;
    res_t        r;
    // elapsed wraps modulo 2^64, so a step back in time refills hugely
    elapsed = stamp - bkt[is_out].last_stamp;
    refill  = (96'(bkt[is_out].rate) * 96'(elapsed)) / ONE_SEC_NS;
    if (refill > REFILL_CEIL) begin
      refill = REFILL_CEIL;
    end
    level = 33'(bkt[is_out].tokens) + refill[32:0];
    if (level > 33'(bkt[is_out].burst)) begin
      bkt[is_out].tokens = bkt[is_out].burst;
    end else begin
      bkt[is_out].tokens = level[31:0];
    end
    bkt[is_out].last_stamp = stamp;
    // length in bits; rate zero lets everything through untouched
    bits = 32'(len) << LEN_SHIFT;
    pass = (bits <= bkt[is_out].tokens) || (bkt[is_out].rate == '0);
    if (pass) begin
      if (bkt[is_out].rate != '0) begin
        bkt[is_out].tokens = bkt[is_out].tokens - bits;
      end
      bkt[is_out].bytes   = bkt[is_out].bytes + 64'(len);
      bkt[is_out].packets = bkt[is_out].packets + 64'd1;
      packets_passed++;
    end else begin
      packets_dropped++;
    end
    r.accept       = pass;
    r.tokens_left  = bkt[is_out].tokens;
    r.byte_total   = bkt[is_out].bytes;
    r.packet_total = bkt[is_out].packets;
    return r;
  endfunction

  // send one packet beat, idling at random first; predict at the accepting edge
  task automatic send_packet(input logic is_out, input logic [15:0] len,
                             input logic [63:0] stamp);
    while (pkt_gaps && $urandom_range(99) < 30) begin
      pkt_if.valid <= 1'b0;
      @(posedge clk);
    end
    pkt_if.valid         <= 1'b1;
    pkt_if.direction_out <= is_out;
    pkt_if.packet_length <= len;
    pkt_if.now_ns        <= stamp;
    do @(posedge clk); while (pkt_if.ready !== 1'b1);
    verdict_q.push_back(police_packet(is_out, len, stamp));
    packets_sent++;
  endtask

  // stop sending, let every owed verdict come back, then let the pipe empty
  task automatic wait_drained();
    pkt_if.valid <= 1'b0;
    while (verdict_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // apb write: setup phase, access phase, then the bus idles before the task returns
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RX_RATE: begin
        bkt[DIR_IN].rate = value;
      end
      REG_RX_BURST: begin
        bkt[DIR_IN].burst = value;
      end
      REG_TX_RATE: begin
        bkt[DIR_OUT].rate = value;
      end
      REG_TX_BURST: begin
        bkt[DIR_OUT].burst = value;
      end
      default: begin
      end
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // program both buckets; caller makes sure the block is idle
  task automatic set_policy(input logic [31:0] rx_rate, input logic [31:0] rx_burst,
                            input logic [31:0] tx_rate, input logic [31:0] tx_burst);
    write_reg(REG_RX_RATE, rx_rate);
    write_reg(REG_RX_BURST, rx_burst);
    write_reg(REG_TX_RATE, tx_rate);
    write_reg(REG_TX_BURST, tx_burst);
    policies++;
  endtask

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(5))
      0: return '0;
      1: return ALL_ONES;
      2: return $urandom_range(1, 1000);
      3: return $urandom_range(1_000_000, 100_000_000);
      4: return $urandom_range(100_000_000, ALL_ONES);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_burst();
    case ($urandom_range(4))
      0: return '0;
      1: return ALL_ONES;
      2: return $urandom_range(0, 20_000);
      3: return $urandom_range(0, 2_000_000);
      default: return $urandom();
    endcase
  endfunction

  // result checker: every accepted result beat against the oldest verdict
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result beat with nothing owed, tokens_left",
                        64'(res_if.tokens_left), 64'd0);
      end else begin
        want = verdict_q.pop_front();
        results_checked++;
        if (res_if.accept !== want.accept) begin
          report_mismatch("accept", 64'(res_if.accept), 64'(want.accept));
        end
        if (res_if.tokens_left !== want.tokens_left) begin
          report_mismatch("tokens_left", 64'(res_if.tokens_left), 64'(want.tokens_left));
        end
        if (res_if.byte_total !== want.byte_total) begin
          report_mismatch("byte_total", res_if.byte_total, want.byte_total);
        end
        if (res_if.packet_total !== want.packet_total) begin
          report_mismatch("packet_total", res_if.packet_total, want.packet_total);
        end
      end
    end
  end

  // result receiver: drops ready at random, about 30 percent of the time, while res_stalls is set
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= !res_stalls || ($urandom_range(99) >= 30);
    end
  end

  // reset config: both rates zero, so everything passes and buckets stay empty
  task automatic test_policing_off();
    send_packet(DIR_IN, 16'd0, 64'd0);
    send_packet(DIR_OUT, 16'hFFFF, 64'd0);
    send_packet(DIR_IN, 16'hFFFF, 64'd1000);
    send_packet(DIR_OUT, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_drained();
  endtask

  // inbound at one bit per ns with a 100k burst, outbound wide open
  task automatic test_bucket_edges();
    set_policy(32'd1_000_000_000, 32'd100_000, ALL_ONES, ALL_ONES);
    // 1000 ns of refill, then a packet of exactly that many bits
    send_packet(DIR_IN, 16'd0, 64'd2000);
    send_packet(DIR_IN, 16'd125, 64'd2000);
    // one bit short: dropped, but the refill still lands
    send_packet(DIR_IN, 16'd1, 64'd2007);
    send_packet(DIR_IN, 16'd1, 64'd2008);
    // long gap: bucket capped at the burst
    send_packet(DIR_IN, 16'd0, 64'd1_002_008);
    // clock steps back: elapsed wraps, bucket fills
    send_packet(DIR_IN, 16'd10, 64'd2000);
    // outbound stamp wraps past zero: one ns of refill, jumbo packet dropped
    send_packet(DIR_OUT, 16'hFFFF, 64'd0);
    // huge elapsed at max rate: refill saturates, bucket full at max burst
    send_packet(DIR_OUT, 16'hFFFF, 64'h8000_0000_0000_0000);
    send_packet(DIR_OUT, 16'hFFFF, 64'h8000_0000_0000_0000);
    wait_drained();
  endtask

  // policy changes on a live bucket
  task automatic test_policy_changes();
    // inbound burst drops below the tokens held; outbound goes to rate zero
    set_policy(32'd1_000_000_000, 32'd500, 32'd0, 32'd1000);
    send_packet(DIR_IN, 16'd0, 64'd2000);
    send_packet(DIR_IN, 16'd63, 64'd2000);
    // rate zero: tokens clipped to burst, never spent
    send_packet(DIR_OUT, 16'hFFFF, 64'h8000_0000_0000_0005);
    send_packet(DIR_OUT, 16'hFFFF, 64'd10);
    wait_drained();
    // slowest nonzero rate inbound; outbound with an empty bucket
    set_policy(32'd1, ALL_ONES, ALL_ONES, 32'd0);
    send_packet(DIR_IN, 16'd0, 64'd1_000_002_000);
    send_packet(DIR_OUT, 16'd0, 64'd20);
    send_packet(DIR_OUT, 16'd1, 64'd30);
    wait_drained();
  endtask

  // random traffic across nine policy settings, 100 packets each
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    int unsigned mode;
    int unsigned span;
    logic [15:0] len;
    clock_ns = {$urandom(), $urandom()};
    for (phase = 0; phase < 9; phase++) begin
      wait_drained();
      case (phase)
        0: set_policy(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        1: set_policy(ALL_ONES, 32'd0, 32'd1, ALL_ONES);
        default: set_policy(pick_rate(), pick_burst(), pick_rate(), pick_burst());
      endcase
      case ($urandom_range(2))
        0: span = 1000;
        1: span = 100_000;
        default: span = 10_000_000;
      endcase
      // one phase runs flat out on both sides
      pkt_gaps   = (phase != 4);
      res_stalls = (phase != 4);
      for (n = 0; n < 100; n++) begin
        // halfway through one phase, hold off until the block has caught up
        if (phase == 2 && n == 50) begin
          wait_drained();
        end
        mode = $urandom_range(99);
        if (mode < 3) begin
          // jump anywhere: forward or backward, all stamp bits move
          clock_ns = {$urandom(), $urandom()};
        end else if (mode >= 10) begin
          clock_ns = clock_ns + 64'($urandom_range(0, span));
        end
        case ($urandom_range(9))
          0: len = 16'd0;
          1: len = 16'hFFFF;
          2, 3: len = 16'($urandom_range(0, 65535));
          default: len = 16'($urandom_range(20, 1500));
        endcase
        send_packet(1'($urandom_range(1)), len, clock_ns);
      end
    end
    pkt_gaps   = 1'b1;
    res_stalls = 1'b1;
    wait_drained();
  endtask

  initial begin
    // everything known from time zero
    rst                  <= 1'b1;
    pkt_if.valid         <= 1'b0;
    pkt_if.direction_out <= DIR_IN;
    pkt_if.packet_length <= '0;
    pkt_if.now_ns        <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    pkt_gaps   = 1'b1;
    res_stalls = 1'b1;
    clock_ns   = '0;
    mismatches      = 0;
    packets_sent    = 0;
    packets_passed  = 0;
    packets_dropped = 0;
    results_checked = 0;
    reg_writes      = 0;
    policies        = 0;
    // predictor starts from the reset state: all zero
    for (int i = 0; i < 2; i++) begin
      bkt[i] = '{default: '0};
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_policing_off();
    test_bucket_edges();
    test_policy_changes();
    test_random_traffic();

    $display("covered: %0d packets (%0d passed, %0d dropped), %0d results checked",
             packets_sent, packets_passed, packets_dropped, results_checked);
    $display("covered: %0d policy settings via %0d register writes, %0d mismatches",
             policies, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("[dual_token_bucket_policer_top] OK");
    end else begin
      $display("[dual_token_bucket_policer_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/dtbp_pkg.sv
hw/rtl/dtbp_in_if.sv
hw/rtl/dtbp_out_if.sv
hw/rtl/dtbp_cfg.sv
hw/rtl/dtbp_refill.sv
hw/rtl/dtbp_bucket.sv
hw/rtl/dtbp_out_fifo.sv
hw/rtl/dual_token_bucket_policer_top.sv
dv/dual_token_bucket_policer_top_test.sv
